// File: rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
    localparam int EXT_W     = 64;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_DIV_ZERO = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD_GO,
        ST_GCD_WAIT,
        ST_DIVN_GO,
        ST_DIVN_WAIT,
        ST_DIVD_GO,
        ST_DIVD_WAIT,
        ST_DONE
    } rau_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

// File: rtl/rau_gcd.sv
// Binary GCD engine: one subtract/shift step per cycle, strips common powers of two from the pair.
module rau_gcd #(
    parameter int MW = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MW-1:0]       num_in,
    input  logic [MW-1:0]       den_in,
    output rau_pkg::unit_sts_t  sts,
    output logic [MW-1:0]       num_out,
    output logic [MW-1:0]       den_out,
    output logic [MW-1:0]       gcd_out
);
    import rau_pkg::*;

    logic [MW-1:0] a_reg, a_next;
    logic [MW-1:0] b_reg, b_next;
    logic [MW-1:0] n_reg, n_next;
    logic [MW-1:0] d_reg, d_next;
    logic          busy_reg, busy_next;
    logic          fin;
    logic [MW:0]   d_ab;
    logic [MW-1:0] d_ba;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        n_reg <= n_next;
        d_reg <= d_next;
    end

    always_comb begin
        fin       = busy_reg && ((a_reg == '0) || (b_reg == '0));
        d_ab      = {1'b0, a_reg} - {1'b0, b_reg};
        d_ba      = b_reg - a_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        busy_next = busy_reg;
        if (start) begin
            a_next    = num_in;
            b_next    = den_in;
            n_next    = num_in;
            d_next    = den_in;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fin) begin
                busy_next = 1'b0;
            end else if (!a_reg[0] && !b_reg[0]) begin
                a_next = {1'b0, a_reg[MW-1:1]};
                b_next = {1'b0, b_reg[MW-1:1]};
                n_next = {1'b0, n_reg[MW-1:1]};
                d_next = {1'b0, d_reg[MW-1:1]};
            end else if (!a_reg[0]) begin
                a_next = {1'b0, a_reg[MW-1:1]};
            end else if (!b_reg[0]) begin
                b_next = {1'b0, b_reg[MW-1:1]};
            end else if (!d_ab[MW]) begin
                a_next = {1'b0, d_ab[MW-1:1]};
            end else begin
                b_next = {1'b0, d_ba[MW-1:1]};
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = fin;
    assign num_out  = n_reg;
    assign den_out  = d_reg;
    assign gcd_out  = a_reg | b_reg;

endmodule

// File: rtl/rau_div.sv
// Restoring divider, one quotient bit per cycle.
module rau_div #(
    parameter int MW = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MW-1:0]       dividend,
    input  logic [MW-1:0]       divisor,
    output rau_pkg::unit_sts_t  sts,
    output logic [MW-1:0]       quotient
);
    import rau_pkg::*;

    localparam int CW = $clog2(MW);

    logic [MW-1:0] rem_reg, rem_next;
    logic [MW-1:0] quo_reg, quo_next;
    logic [MW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [MW:0]   r_sh;
    logic [MW+1:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        r_sh      = {rem_reg, quo_reg[MW-1]};
        diff      = {1'b0, r_sh} - {2'b00, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[MW+1]) begin
                rem_next = diff[MW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b1};
            end else begin
                rem_next = r_sh[MW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(MW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: combines two fractions and reduces the result by its GCD.
// Add and subtract pass through ST_MUL0, ST_MUL1 and ST_MUL2; multiply and divide skip
// ST_MUL2. The binary GCD engine then reduces the result; a GCD of 1 skips both
// divisions. Errors go straight to the result, and a zero result skips the reduction.
// Throughput: one transaction at a time; s_tready returns in the same cycle that the result is presented on m_tdata.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // s_tdata: first_numerator, first_denominator, second_numerator, second_denominator
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]     s_tdata,
    // s_tuser: action
    input  logic [1:0]                                s_tuser,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // m_tdata: result_numerator, result_denominator
    output logic [rau_pkg::NUM_OUT_W+rau_pkg::DEN_OUT_W-1:0] m_tdata,
    // m_tuser: status
    output logic [1:0]                                m_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int OW = NUM_OUT_W + DEN_OUT_W;

    rau_state_t    state_reg, state_next;
    action_t       act_reg, act_next;
    status_t       stat_reg, stat_next;
    logic [W-1:0]  mn1_reg, mn1_next, md1_reg, md1_next;
    logic [W-1:0]  mn2_reg, mn2_next, md2_reg, md2_next;
    logic          s1_reg, s1_next, s2_reg, s2_next;
    logic [MW-1:0] pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic [MW-1:0] num_reg, num_next, den_reg, den_next, g_reg, g_next;
    logic          neg_reg, neg_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OW-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;

    logic [W-1:0]  in_n1, in_d1, in_n2, in_d2;
    logic [W-1:0]  mul_x, mul_y;
    logic [MW-1:0] prod;
    logic [MW:0]   ta, tb, sum;
    logic          neg_b;
    logic [MW-1:0] comb_num, comb_den;
    logic          comb_neg;
    logic [MW:0]   num_sx;
    logic [EXT_W-1:0] num_ext, den_ext;

    logic          gcd_start, div_start;
    unit_sts_t     gcd_sts, div_sts;
    logic [MW-1:0] gcd_num, gcd_den, gcd_g, div_dividend, div_quo;

    assign in_n1 = s_tdata[W-1:0];
    assign in_d1 = s_tdata[2*W-1:W];
    assign in_n2 = s_tdata[3*W-1:2*W];
    assign in_d2 = s_tdata[4*W-1:3*W];

    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                mul_x = mn1_reg;
                mul_y = (act_reg == ACT_MUL) ? mn2_reg : md2_reg;
            end
            ST_MUL1: begin
                case (act_reg) inside
                    ACT_ADD, ACT_SUB: begin
                        mul_x = mn2_reg;
                        mul_y = md1_reg;
                    end
                    ACT_MUL: begin
                        mul_x = md1_reg;
                        mul_y = md2_reg;
                    end
                    default: begin
                        mul_x = md1_reg;
                        mul_y = mn2_reg;
                    end
                endcase
            end
            default: begin
                mul_x = md1_reg;
                mul_y = md2_reg;
            end
        endcase
        prod = MW'(mul_x) * MW'(mul_y);
    end

    always_comb begin
        neg_b    = s2_reg ^ (act_reg == ACT_SUB);
        ta       = s1_reg ? -{1'b0, pa_reg} : {1'b0, pa_reg};
        tb       = neg_b ? -{1'b0, pb_reg} : {1'b0, pb_reg};
        sum      = ta + tb;
        case (act_reg) inside
            ACT_ADD, ACT_SUB: begin
                comb_neg = sum[MW];
                comb_num = sum[MW] ? MW'(-sum) : sum[MW-1:0];
                comb_den = pc_reg;
            end
            default: begin
                comb_neg = s1_reg ^ s2_reg;
                comb_num = pa_reg;
                comb_den = pb_reg;
            end
        endcase
        num_sx  = neg_reg ? -{1'b0, num_reg} : {1'b0, num_reg};
        num_ext = {{(EXT_W-MW-1){num_sx[MW]}}, num_sx};
        den_ext = {{(EXT_W-MW){1'b0}}, den_reg};
    end

    assign gcd_start    = (state_reg == ST_GCD_GO);
    assign div_start    = (state_reg == ST_DIVN_GO) || (state_reg == ST_DIVD_GO);
    assign div_dividend = (state_reg == ST_DIVN_GO) ? num_reg : den_reg;

    rau_gcd #(.MW(MW)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .num_in  (num_reg),
        .den_in  (den_reg),
        .sts     (gcd_sts),
        .num_out (gcd_num),
        .den_out (gcd_den),
        .gcd_out (gcd_g)
    );

    rau_div #(.MW(MW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        act_reg     <= act_next;
        stat_reg    <= stat_next;
        mn1_reg     <= mn1_next;
        md1_reg     <= md1_next;
        mn2_reg     <= mn2_next;
        md2_reg     <= md2_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        pc_reg      <= pc_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        g_reg       <= g_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        stat_next     = stat_reg;
        mn1_next      = mn1_reg;
        md1_next      = md1_reg;
        mn2_next      = mn2_reg;
        md2_next      = md2_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        pc_next       = pc_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        g_next        = g_reg;
        neg_next      = neg_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next = action_t'(s_tuser);
                    mn1_next = in_n1[W-1] ? (~in_n1 + 1'b1) : in_n1;
                    md1_next = in_d1[W-1] ? (~in_d1 + 1'b1) : in_d1;
                    mn2_next = in_n2[W-1] ? (~in_n2 + 1'b1) : in_n2;
                    md2_next = in_d2[W-1] ? (~in_d2 + 1'b1) : in_d2;
                    s1_next  = in_n1[W-1] ^ in_d1[W-1];
                    s2_next  = in_n2[W-1] ^ in_d2[W-1];
                    num_next = '0;
                    den_next = MW'(1);
                    neg_next = 1'b0;
                    if ((in_d1 == '0) || (in_d2 == '0)) begin
                        stat_next  = STAT_ZERO_DEN;
                        state_next = ST_DONE;
                    end else if ((action_t'(s_tuser) == ACT_DIV) && (in_n2 == '0)) begin
                        stat_next  = STAT_DIV_ZERO;
                        state_next = ST_DONE;
                    end else begin
                        stat_next  = STAT_OK;
                        state_next = ST_MUL0;
                    end
                end
            end
            ST_MUL0: begin
                pa_next    = prod;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                pb_next    = prod;
                state_next = ((act_reg == ACT_ADD) || (act_reg == ACT_SUB)) ? ST_MUL2 : ST_COMB;
            end
            ST_MUL2: begin
                pc_next    = prod;
                state_next = ST_COMB;
            end
            ST_COMB: begin
                if (comb_num == '0) begin
                    num_next   = '0;
                    den_next   = MW'(1);
                    neg_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    num_next   = comb_num;
                    den_next   = comb_den;
                    neg_next   = comb_neg;
                    state_next = ST_GCD_GO;
                end
            end
            ST_GCD_GO: begin
                state_next = ST_GCD_WAIT;
            end
            ST_GCD_WAIT: begin
                if (gcd_sts.done) begin
                    num_next   = gcd_num;
                    den_next   = gcd_den;
                    g_next     = gcd_g;
                    state_next = (gcd_g == MW'(1)) ? ST_DONE : ST_DIVN_GO;
                end
            end
            ST_DIVN_GO: begin
                state_next = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT: begin
                if (div_sts.done) begin
                    num_next   = div_quo;
                    state_next = ST_DIVD_GO;
                end
            end
            ST_DIVD_GO: begin
                state_next = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT: begin
                if (div_sts.done) begin
                    den_next   = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {den_ext[DEN_OUT_W-1:0], num_ext[NUM_OUT_W-1:0]};
                    m_tuser_next  = stat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg != STAT_OK)) |->
            (m_tdata_reg[NUM_OUT_W-1:0] == '0) &&
            (m_tdata_reg[OW-1:NUM_OUT_W] == DEN_OUT_W'(1)))
        else $error("error transaction without 0/1 result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(gcd_sts.busy && div_sts.busy))
        else $error("gcd engine and divider active together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!gcd_sts.busy && !div_sts.busy))
        else $error("transaction accepted while arithmetic busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (OPERAND_WIDTH <= 16)) |-> (m_tdata_reg[OW-1:NUM_OUT_W] != '0))
        else $error("zero result denominator");

endmodule
